/* rtl/txrb_pkg.sv */
// ----------------------------------------------------------------------------
// txrb_pkg
// Shared types and codes for the transmit ring buffer chunker.
// ----------------------------------------------------------------------------
package txrb_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_BYTE  = 2'd1,
    OP_DONE  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_IGNORED = 2'd2
  } status_t;

  // message admission state
  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_ADMIT = 2'd1,
    MODE_DROP  = 2'd2
  } mode_t;

  localparam int MsgLenW   = 16;
  localparam int ByteW     = 8;
  localparam int ReadAddrW = 9;
  localparam int XferAddrW = 9;
  localparam int XferCntW  = 10;
  localparam int DropW     = 32;

endpackage

/* rtl/tx_ring_buffer_dma_chunker.sv */
// ----------------------------------------------------------------------------
// tx_ring_buffer_dma_chunker
// Byte ring buffer that admits whole messages and hands out contiguous
// transfer chunks to a transmitter.
// ----------------------------------------------------------------------------
// Every item gives one result. The block takes one item per clock cycle while
// the output is not stalled; the item sits in an input register while the
// pointer and space logic works on it, and the result lands in an output
// register. The byte store is a RAM whose read is issued as the item is
// taken, so stored-byte reads keep the same one-per-cycle rate; a
// byte written by the item just ahead is forwarded around the RAM. A begin item
// admits its message only if the free space (depth minus used minus one) is at
// least its length, else the length is added to a wrapping drop total and its
// bytes are ignored. A transfer starts when an admitted message completes or is
// cut short by a new begin, and after each transfer done, if no transfer is in
// flight; it covers the run from the tail to the head or to the buffer's end.
// The byte store is not cleared at reset; reading an unwritten offset returns
// an arbitrary byte.
module tx_ring_buffer_dma_chunker
  import txrb_pkg::*;
#(
  parameter int BUF_DEPTH = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic [MsgLenW-1:0]   msg_len,
  input  logic [ByteW-1:0]     data_byte,
  input  logic [ReadAddrW-1:0] read_addr,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic                 xfer_start,
  output logic [XferAddrW-1:0] xfer_addr,
  output logic [XferCntW-1:0]  xfer_count,
  output logic [ByteW-1:0]     read_data,
  output logic [DropW-1:0]     drop_total
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam logic [AW:0]   DepthW = (AW + 1)'(BUF_DEPTH);
  localparam logic [AW-1:0] LastPtr = AW'(BUF_DEPTH - 1);

  // pipeline control
  logic advance, in_fire, s1_fire;
  logic s1_valid;

  // input register
  op_t                  s1_op;
  logic [MsgLenW-1:0]   s1_len;
  logic [ByteW-1:0]     s1_byte;
  logic [ReadAddrW-1:0] s1_raddr;

  // ring state
  logic [AW-1:0]      write_ptr, write_ptr_next;
  logic [AW-1:0]      read_ptr, read_ptr_next;
  logic [CW-1:0]      inflight_count, inflight_count_next;
  logic               xfer_busy, xfer_busy_next;
  logic [DropW-1:0]   dropped_bytes, dropped_bytes_next;
  logic [MsgLenW-1:0] bytes_pending, bytes_pending_next;
  mode_t              msg_mode, msg_mode_next;

  // ram and forwarding
  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  logic [ByteW-1:0] ram_rdata;
  logic             byp_hit;
  logic [ByteW-1:0] byp_data;
  logic [ByteW-1:0] s1_rdata;

  // start logic
  logic          start_req;
  logic [AW-1:0] wp_eff, rp_eff;
  logic          busy_eff;
  logic          start_ok;
  logic [CW-1:0] start_len;

  // space and pointer arithmetic
  logic [AW:0]   used_space, free_space;
  logic [AW:0]   rp_sum;
  logic [AW-1:0] rp_adv, wp_inc;

  // result values
  status_t          res_status;
  logic [ByteW-1:0] res_rdata;

  assign advance  = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && advance;
  assign in_stall = s1_valid && !advance;
  assign in_fire  = in_valid && !in_stall;

  // input register and valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op    <= op_t'(operation);
      s1_len   <= msg_len;
      s1_byte  <= data_byte;
      s1_raddr <= read_addr;
    end
  end

  // byte store, read issued on transfer in
  assign ram_raddr = AW'(read_addr);
  assign ram_we    = s1_fire && (s1_op == OP_BYTE) && (msg_mode == MODE_ADMIT);

  txrb_ram #(
    .WIDTH(ByteW),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(write_ptr),
    .wdata(s1_byte),
    .re   (in_fire),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // forward a write that collides with the read taken on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_hit <= 1'b0;
    end else if (in_fire) begin
      byp_hit <= ram_we && (write_ptr == ram_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byp_data <= s1_byte;
    end
  end

  assign s1_rdata = byp_hit ? byp_data : ram_rdata;

  // occupancy and pointer steps
  always_comb begin
    if (write_ptr >= read_ptr) begin
      used_space = {1'b0, write_ptr} - {1'b0, read_ptr};
    end else begin
      used_space = {1'b0, write_ptr} + DepthW - {1'b0, read_ptr};
    end
    free_space = DepthW - (AW + 1)'(1) - used_space;
    wp_inc     = (write_ptr == LastPtr) ? '0 : write_ptr + AW'(1);
    rp_sum     = {1'b0, read_ptr} + (AW + 1)'(inflight_count);
    rp_adv     = (rp_sum >= DepthW) ? AW'(rp_sum - DepthW) : AW'(rp_sum);
  end

  // message state next value
  always_comb begin
    msg_mode_next      = msg_mode;
    bytes_pending_next = bytes_pending;
    dropped_bytes_next = dropped_bytes;
    write_ptr_next     = write_ptr;
    start_req          = 1'b0;
    res_status         = STATUS_OK;
    unique case (s1_op)
      OP_BEGIN: begin
        start_req          = (msg_mode == MODE_ADMIT);
        msg_mode_next      = MODE_NONE;
        bytes_pending_next = s1_len;
        if (s1_len != '0) begin
          if ((MsgLenW + 1)'(free_space) < (MsgLenW + 1)'(s1_len)) begin
            dropped_bytes_next = dropped_bytes + DropW'(s1_len);
            msg_mode_next      = MODE_DROP;
            res_status         = STATUS_DROPPED;
          end else begin
            msg_mode_next = MODE_ADMIT;
          end
        end
      end
      OP_BYTE: begin
        if (msg_mode == MODE_ADMIT) begin
          write_ptr_next     = wp_inc;
          bytes_pending_next = bytes_pending - MsgLenW'(1);
          if (bytes_pending == MsgLenW'(1)) begin
            msg_mode_next = MODE_NONE;
            start_req     = 1'b1;
          end
        end else begin
          res_status = STATUS_IGNORED;
          if (msg_mode == MODE_DROP) begin
            bytes_pending_next = bytes_pending - MsgLenW'(1);
            if (bytes_pending == MsgLenW'(1)) begin
              msg_mode_next = MODE_NONE;
            end
          end
        end
      end
      OP_DONE: begin
        if (xfer_busy) begin
          start_req = 1'b1;
        end else begin
          res_status = STATUS_IGNORED;
        end
      end
      OP_READ: begin
        if (32'(s1_raddr) >= 32'(BUF_DEPTH)) begin
          res_status = STATUS_IGNORED;
        end
      end
      default: begin
        res_status = STATUS_IGNORED;
      end
    endcase
  end

  // transfer start, seen against the pointers this item leaves
  always_comb begin
    wp_eff   = write_ptr_next;
    rp_eff   = read_ptr;
    busy_eff = xfer_busy;
    if (s1_op == OP_DONE && xfer_busy) begin
      rp_eff   = rp_adv;
      busy_eff = 1'b0;
    end
    start_ok = start_req && !busy_eff && (wp_eff != rp_eff);
    if (wp_eff > rp_eff) begin
      start_len = CW'(wp_eff - rp_eff);
    end else begin
      start_len = CW'(DepthW - {1'b0, rp_eff});
    end
    read_ptr_next       = rp_eff;
    xfer_busy_next      = busy_eff;
    inflight_count_next = busy_eff ? inflight_count : '0;
    if (start_ok) begin
      xfer_busy_next      = 1'b1;
      inflight_count_next = start_len;
    end
    res_rdata = '0;
    if (s1_op == OP_READ && res_status == STATUS_OK) begin
      res_rdata = s1_rdata;
    end
  end

  // ring state registers, committed as the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr      <= '0;
      read_ptr       <= '0;
      inflight_count <= '0;
      xfer_busy      <= 1'b0;
      dropped_bytes  <= '0;
      bytes_pending  <= '0;
      msg_mode       <= MODE_NONE;
    end else if (s1_fire) begin
      write_ptr      <= write_ptr_next;
      read_ptr       <= read_ptr_next;
      inflight_count <= inflight_count_next;
      xfer_busy      <= xfer_busy_next;
      dropped_bytes  <= dropped_bytes_next;
      bytes_pending  <= bytes_pending_next;
      msg_mode       <= msg_mode_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      status     <= res_status;
      xfer_start <= start_ok;
      xfer_addr  <= start_ok ? XferAddrW'(rp_eff) : '0;
      xfer_count <= start_ok ? XferCntW'(start_len) : '0;
      read_data  <= res_rdata;
      drop_total <= dropped_bytes_next;
    end
  end

endmodule

/* rtl/txrb_ram.sv */
// ----------------------------------------------------------------------------
// txrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module txrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
